>>> src/ecg_pkg.sv
// Package for the easing curve generator: constants, payload structs, cell types.
// No dependencies.
package ecg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_BITS = 16;
    localparam int Q         = 30;
    localparam int QW        = Q + 1;          // Q30 value up to and including one
    localparam int OUT_W     = FRAC_BITS + 1;
    localparam int NUM_W     = TIME_BITS + FRAC_BITS;
    localparam int DIV_CELLS = FRAC_BITS + 1;  // quotient bits, t may equal one
    localparam int CRV_CELLS = 7;              // multiply steps of the curve chain

    localparam logic [QW-1:0] ONE30  = QW'(64'd1 << Q);
    localparam logic [QW-1:0] HALF30 = QW'(64'd1 << (Q - 1));

    // C1 is above one, so the coefficients carry the integer bit too
    localparam logic [QW-1:0] C1 = QW'(32'd1686629713);
    localparam logic [QW-1:0] C3 = QW'(32'd693598668);
    localparam logic [QW-1:0] C5 = QW'(32'd85569306);
    localparam logic [QW-1:0] C7 = QW'(32'd5026995);
    localparam logic [QW-1:0] C9 = QW'(32'd172272);

    typedef enum logic [3:0] {
        EASE_NONE        = 4'd0,
        EASE_LINEAR      = 4'd1,
        EASE_SINE_IN     = 4'd2,
        EASE_SINE_OUT    = 4'd3,
        EASE_SINE_INOUT  = 4'd4,
        EASE_QUAD_IN     = 4'd5,
        EASE_QUAD_OUT    = 4'd6,
        EASE_QUAD_INOUT  = 4'd7,
        EASE_CUBIC_IN    = 4'd8,
        EASE_CUBIC_OUT   = 4'd9,
        EASE_CUBIC_INOUT = 4'd10
    } t_ease;

    typedef struct packed {
        logic [3:0]           ease_type;
        logic [TIME_BITS-1:0] elapsed_ticks;
        logic [TIME_BITS-1:0] duration_ticks;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] eased_value;
        logic             bad_duration;
    } t_out;

    // Sideband that rides along a chain of cells.
    typedef struct packed {
        logic       valid;
        logic [3:0] ease_type;
        logic       bad;
    } t_tag;

    // Divider cell payload: partial remainder, divisor, quotient so far.
    typedef struct packed {
        t_tag                 tag;
        logic [NUM_W:0]       rem;
        logic [TIME_BITS-1:0] div;
        logic [OUT_W-1:0]     quo;
    } t_div;

    // Curve cell payload.
    typedef struct packed {
        t_tag          tag;
        logic          upper;   // second half of an in-out curve
        logic [QW-1:0] t;       // progress in Q30
        logic [QW-1:0] x;       // argument being worked on
        logic [QW-1:0] x2;      // x squared
        logic [QW-1:0] acc;     // Horner or power accumulator
    } t_crv;

    function automatic logic [QW-1:0] mulq(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        p = a * b;
        return QW'(p >> Q);
    endfunction

endpackage

>>> src/ecg_div_cell.sv
// One restoring division step: produces one quotient bit per cell.
// Depends on ecg_pkg.
module ecg_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [4:0]    i_shift,
    input  ecg_pkg::t_div i_d,
    output ecg_pkg::t_div o_d
);
    ecg_pkg::t_div r_d, n_d;
    logic [ecg_pkg::NUM_W:0] w_trial;

    always_comb begin
        w_trial = (ecg_pkg::NUM_W + 1)'(i_d.div) << i_shift;
        n_d     = i_d;
        n_d.quo = {i_d.quo[ecg_pkg::OUT_W-2:0], 1'b0};
        if (i_d.rem >= w_trial) begin
            n_d.rem    = i_d.rem - w_trial;
            n_d.quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> src/ecg_crv_cell.sv
// One multiply step of the curve evaluation; the step's role is set by its index.
// Depends on ecg_pkg.
module ecg_crv_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [2:0]    i_step,
    input  ecg_pkg::t_crv i_c,
    output ecg_pkg::t_crv o_c
);
    ecg_pkg::t_crv r_c, n_c;
    logic          w_sine;
    logic [ecg_pkg::QW-1:0] w_m;
    logic [ecg_pkg::QW-1:0] w_k;

    // steps: 0 x2=x*x, acc=C9 or x2; 1..4 Horner acc=Ck-x2*acc and 5 acc=x*acc (sine only); 6 acc=x2*x (cubes)
    always_comb begin
        w_sine = (i_c.tag.ease_type == ecg_pkg::EASE_SINE_IN) ||
                 (i_c.tag.ease_type == ecg_pkg::EASE_SINE_OUT) ||
                 (i_c.tag.ease_type == ecg_pkg::EASE_SINE_INOUT);
        case (i_step)
            3'd1:    w_k = ecg_pkg::C7;
            3'd2:    w_k = ecg_pkg::C5;
            3'd3:    w_k = ecg_pkg::C3;
            default: w_k = ecg_pkg::C1;
        endcase
        n_c = i_c;
        case (i_step) inside
            3'd0: begin
                w_m    = ecg_pkg::mulq(i_c.x, i_c.x);
                n_c.x2 = w_m;
                n_c.acc = w_sine ? ecg_pkg::C9 : w_m;
            end
            3'd1, 3'd2, 3'd3, 3'd4: begin
                w_m = ecg_pkg::mulq(i_c.x2, i_c.acc);
                if (w_sine) n_c.acc = w_k - w_m;
            end
            3'd5: begin
                w_m = ecg_pkg::mulq(i_c.x, i_c.acc);
                if (w_sine) n_c.acc = w_m;
            end
            default: begin
                w_m = ecg_pkg::mulq(i_c.x2, i_c.x);
                if (!w_sine) n_c.acc = w_m;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_c = r_c;
endmodule

>>> src/easing_curve_generator.sv
// Top level of the easing curve generator: divider chain, curve chain, output stage.
// Depends on ecg_pkg, ecg_div_cell, ecg_crv_cell.
//
// Fully pipelined: one beat in per cycle unless the output stalls; each result passes
// through one input register, 17 divider cells giving one quotient bit each, one
// setup stage, 7 multiply cells and one output register. The whole pipe moves
// only while the output register is empty or being drained, so a stalled output
// holds everything in place and nothing is lost.
module easing_curve_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  ecg_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output ecg_pkg::t_out o_data
);
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Input stage: clamp elapsed, flag zero duration.
    ecg_pkg::t_div r_in;
    ecg_pkg::t_div w_dv [0:ecg_pkg::DIV_CELLS];
    logic [ecg_pkg::TIME_BITS-1:0] w_e;

    assign w_e = (i_data.elapsed_ticks > i_data.duration_ticks) ?
                 i_data.duration_ticks : i_data.elapsed_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.tag.valid <= 1'b0;
        end else if (w_en) begin
            r_in.tag.valid     <= i_valid;
            r_in.tag.ease_type <= i_data.ease_type;
            r_in.tag.bad       <= (i_data.duration_ticks == '0);
            r_in.rem <= (ecg_pkg::NUM_W + 1)'(w_e) << ecg_pkg::FRAC_BITS;
            r_in.div <= i_data.duration_ticks;
            r_in.quo <= '0;
        end
    end

    assign w_dv[0] = r_in;

    for (genvar g = 0; g < ecg_pkg::DIV_CELLS; g++) begin : g_div
        ecg_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_shift(5'(ecg_pkg::DIV_CELLS - 1 - g)),
            .i_d    (w_dv[g]),
            .o_d    (w_dv[g+1])
        );
    end

    // Setup: Q30 progress and the argument for the chosen curve.
    ecg_pkg::t_crv r_su, n_su;
    ecg_pkg::t_crv w_cv [0:ecg_pkg::CRV_CELLS];
    ecg_pkg::t_div w_q;
    logic [ecg_pkg::QW-1:0] w_t, w_u;

    always_comb begin
        w_q = w_dv[ecg_pkg::DIV_CELLS];
        w_t = ecg_pkg::QW'(w_q.quo) << (ecg_pkg::Q - ecg_pkg::FRAC_BITS);
        w_u = ecg_pkg::ONE30 - w_t;
        n_su.tag  = w_q.tag;
        n_su.t    = w_t;
        n_su.x2   = '0;
        n_su.acc  = '0;
        n_su.upper = 1'b0;
        n_su.x    = w_t;
        case (w_q.tag.ease_type) inside
            ecg_pkg::EASE_SINE_IN, ecg_pkg::EASE_QUAD_OUT, ecg_pkg::EASE_CUBIC_OUT:
                n_su.x = w_u;
            ecg_pkg::EASE_SINE_INOUT: begin
                n_su.upper = (w_t > ecg_pkg::HALF30);
                n_su.x = n_su.upper ? ecg_pkg::QW'({w_t, 1'b0} - ecg_pkg::ONE30)
                                    : ecg_pkg::QW'(ecg_pkg::ONE30 - {w_t, 1'b0});
            end
            ecg_pkg::EASE_QUAD_INOUT, ecg_pkg::EASE_CUBIC_INOUT: begin
                n_su.upper = (w_t >= ecg_pkg::HALF30);
                n_su.x = n_su.upper ? w_u : w_t;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su.tag.valid <= 1'b0;
        end else if (w_en) begin
            r_su <= n_su;
        end
    end

    assign w_cv[0] = r_su;

    for (genvar g = 0; g < ecg_pkg::CRV_CELLS; g++) begin : g_crv
        ecg_crv_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_step (3'(g)),
            .i_c    (w_cv[g]),
            .o_c    (w_cv[g+1])
        );
    end

    // Finish: combine, round to FRAC_BITS.
    ecg_pkg::t_crv w_f;
    logic [ecg_pkg::QW-1:0] w_s, w_x2, w_v;
    logic [ecg_pkg::QW+1:0] w_r;

    always_comb begin
        w_f  = w_cv[ecg_pkg::CRV_CELLS];
        w_s  = (w_f.acc > ecg_pkg::ONE30) ? ecg_pkg::ONE30 : w_f.acc;
        w_x2 = w_f.x2;
        case (w_f.tag.ease_type)
            ecg_pkg::EASE_LINEAR:     w_v = w_f.t;
            ecg_pkg::EASE_SINE_IN:    w_v = ecg_pkg::ONE30 - w_s;
            ecg_pkg::EASE_SINE_OUT:   w_v = w_s;
            ecg_pkg::EASE_SINE_INOUT:
                // one plus sine reaches two, so the sum gets a carry bit
                w_v = w_f.upper ? ecg_pkg::QW'(({1'b0, ecg_pkg::ONE30} + {1'b0, w_s}) >> 1)
                                : ecg_pkg::QW'((ecg_pkg::ONE30 - w_s) >> 1);
            ecg_pkg::EASE_QUAD_IN:    w_v = w_x2;
            ecg_pkg::EASE_QUAD_OUT:   w_v = ecg_pkg::ONE30 - w_x2;
            ecg_pkg::EASE_QUAD_INOUT:
                w_v = w_f.upper ? ecg_pkg::ONE30 - (w_x2 << 1) : w_x2 << 1;
            ecg_pkg::EASE_CUBIC_IN:   w_v = w_f.acc;
            ecg_pkg::EASE_CUBIC_OUT:  w_v = ecg_pkg::ONE30 - w_f.acc;
            ecg_pkg::EASE_CUBIC_INOUT:
                w_v = w_f.upper ? ecg_pkg::ONE30 - (w_f.acc << 2) : w_f.acc << 2;
            default:                  w_v = '0;
        endcase
        w_r = ((ecg_pkg::QW + 2)'(w_v) +
               (ecg_pkg::QW + 2)'((64'd1 << (ecg_pkg::Q - ecg_pkg::FRAC_BITS)) >> 1))
              >> (ecg_pkg::Q - ecg_pkg::FRAC_BITS);
    end

    logic r_ov;
    ecg_pkg::t_out r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_f.tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od.bad_duration <= w_f.tag.bad;
            r_od.eased_value  <= w_f.tag.bad ? '0 : w_r[ecg_pkg::OUT_W-1:0];
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;
endmodule
